/* hdl/crlf_line_ring_buffer_unit_defines.svh */
// assertion helpers included by the top-level unit file
`ifndef CRLF_LINE_RING_BUFFER_UNIT_DEFINES_SVH
`define CRLF_LINE_RING_BUFFER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define CLRB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define CLRB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/clrb_pkg.sv */
`default_nettype none

package clrb_pkg;

  // ring geometry
  localparam int unsigned RING_DEPTH = 64;
  localparam int unsigned PTR_W      = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int unsigned LINE_W     = 6;

  localparam logic [PTR_W:0]     DEPTH_WRAP = (PTR_W + 1)'(RING_DEPTH);
  localparam logic [CNT_W-1:0]   DEPTH_CNT  = CNT_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(RING_DEPTH - 1);
  localparam logic [LINE_W-1:0]  LINES_MAX  = LINE_W'(63);

  // characters
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  // input kind
  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_LINE   = 2'd0;
  localparam logic [1:0] STATUS_NOLINE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic push;
    logic scan_start;
    logic scan_rd;
    logic scan_step;
    logic found;
    logic emit_rd;
    logic emit_load;
    logic load_noline;
    logic load_empty;
    logic commit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pop_ok;
    logic hit;
    logic hit_empty;
    logic scan_end;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* hdl/clrb_ram.sv */
`default_nettype none

module clrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* hdl/clrb_ctrl.sv */
`default_nettype none

module clrb_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_mode_i,
  output logic               in_ready_o,
  input  wire clrb_pkg::sts_t sts_i,
  output clrb_pkg::cmd_t     cmd_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_SCAN_RD  = 3'd1;
  localparam logic [2:0] ST_SCAN_CMP = 3'd2;
  localparam logic [2:0] ST_NOLINE   = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;
  localparam logic [2:0] ST_EMIT_RD  = 3'd5;
  localparam logic [2:0] ST_EMIT_LD  = 3'd6;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_mode_i == clrb_pkg::MODE_POP) begin
            if (sts_i.pop_ok) begin
              cmd_o.scan_start = 1'b1;
              state_d          = ST_SCAN_RD;
            end else begin
              state_d = ST_NOLINE;
            end
          end else begin
            cmd_o.push = 1'b1;
          end
        end
      end
      ST_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts_i.hit) begin
          cmd_o.found = 1'b1;
          state_d     = sts_i.hit_empty ? ST_EMPTY : ST_EMIT_RD;
        end else if (sts_i.scan_end) begin
          state_d = ST_NOLINE;
        end else begin
          cmd_o.scan_step = 1'b1;
          state_d         = ST_SCAN_RD;
        end
      end
      ST_NOLINE: begin
        if (sts_i.out_free) begin
          cmd_o.load_noline = 1'b1;
          state_d           = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts_i.out_free) begin
          cmd_o.load_empty = 1'b1;
          cmd_o.commit     = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.commit = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/clrb_dp.sv */
`default_nettype none

module clrb_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire clrb_pkg::cmd_t cmd_i,
  output clrb_pkg::sts_t      sts_o,
  input  wire logic [7:0]     in_byte_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic [1:0]          out_status_o
);

  localparam int unsigned PW = clrb_pkg::PTR_W;
  localparam int unsigned CW = clrb_pkg::CNT_W;
  localparam int unsigned LW = clrb_pkg::LINE_W;

  logic [PW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [CW-1:0] fill_q, fill_d, k_q, k_d, len_q, len_d;
  logic [LW-1:0] lines_q, lines_d;
  logic          last_cr_q, last_cr_d;
  logic          prev_cr_q, prev_cr_d;
  logic          out_valid_q, out_valid_d;
  logic [7:0]    out_byte_q, out_byte_d;
  logic          out_last_q, out_last_d;
  logic [1:0]    out_status_q, out_status_d;

  logic          full;
  logic          we;
  logic          re;
  logic [PW:0]   rd_sum;
  logic [PW-1:0] raddr;
  logic [PW:0]   cm_sum;
  logic [PW-1:0] rp_next;
  logic [CW:0]   k_inc;
  logic [7:0]    rdata;

  // read address wraps once at most
  assign rd_sum = {1'b0, rp_q} + (PW + 1)'(k_q);
  assign raddr  = (rd_sum >= clrb_pkg::DEPTH_WRAP) ? PW'(rd_sum - clrb_pkg::DEPTH_WRAP)
                                                   : PW'(rd_sum);
  // read pointer after line and crlf
  assign cm_sum  = {1'b0, rp_q} + (PW + 1)'(len_q) + (PW + 1)'(2);
  assign rp_next = (cm_sum >= clrb_pkg::DEPTH_WRAP) ? PW'(cm_sum - clrb_pkg::DEPTH_WRAP)
                                                    : PW'(cm_sum);

  assign full  = (fill_q >= clrb_pkg::DEPTH_CNT);
  assign we    = cmd_i.push && !full;
  assign re    = cmd_i.scan_rd || cmd_i.emit_rd;
  assign k_inc = {1'b0, k_q} + (CW + 1)'(1);

  clrb_ram #(
    .WIDTH (8),
    .DEPTH (clrb_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (in_byte_i),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // status to controller
  always_comb begin
    sts_o.pop_ok    = (lines_q != '0) && (fill_q >= CW'(2));
    sts_o.hit       = prev_cr_q && (rdata == clrb_pkg::CH_LF);
    sts_o.hit_empty = (k_q == CW'(1));
    sts_o.scan_end  = (k_inc >= {1'b0, fill_q});
    sts_o.emit_last = (k_inc == {1'b0, len_q});
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  // pointer, count and scan updates
  always_comb begin
    rp_d      = rp_q;
    wp_d      = wp_q;
    fill_d    = fill_q;
    lines_d   = lines_q;
    last_cr_d = last_cr_q;
    k_d       = k_q;
    len_d     = len_q;
    prev_cr_d = prev_cr_q;
    if (we) begin
      wp_d   = (wp_q == clrb_pkg::PTR_LAST) ? '0 : wp_q + PW'(1);
      fill_d = fill_q + CW'(1);
      if (last_cr_q && (in_byte_i == clrb_pkg::CH_LF) && (lines_q < clrb_pkg::LINES_MAX)) begin
        lines_d = lines_q + LW'(1);
      end
      last_cr_d = (in_byte_i == clrb_pkg::CH_CR);
    end
    if (cmd_i.scan_start) begin
      k_d       = '0;
      prev_cr_d = 1'b0;
    end
    if (cmd_i.scan_step) begin
      k_d       = CW'(k_inc);
      prev_cr_d = (rdata == clrb_pkg::CH_CR);
    end
    if (cmd_i.found) begin
      len_d = k_q - CW'(1);
      k_d   = '0;
    end
    if (cmd_i.emit_load) begin
      k_d = CW'(k_inc);
    end
    if (cmd_i.commit) begin
      rp_d    = rp_next;
      fill_d  = fill_q - len_q - CW'(2);
      lines_d = lines_q - LW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_d  = out_valid_q && !out_ready_i;
    out_byte_d   = out_byte_q;
    out_last_d   = out_last_q;
    out_status_d = out_status_q;
    if (cmd_i.emit_load) begin
      out_valid_d  = 1'b1;
      out_byte_d   = rdata;
      out_last_d   = sts_o.emit_last;
      out_status_d = clrb_pkg::STATUS_LINE;
    end else if (cmd_i.load_noline || cmd_i.load_empty) begin
      out_valid_d  = 1'b1;
      out_byte_d   = '0;
      out_last_d   = 1'b1;
      out_status_d = cmd_i.load_empty ? clrb_pkg::STATUS_EMPTY : clrb_pkg::STATUS_NOLINE;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rp_q        <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      lines_q     <= '0;
      last_cr_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rp_q        <= rp_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      lines_q     <= lines_d;
      last_cr_q   <= last_cr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // scan and payload registers
  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    len_q        <= len_d;
    prev_cr_q    <= prev_cr_d;
    out_byte_q   <= out_byte_d;
    out_last_q   <= out_last_d;
    out_status_q <= out_status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign out_last_o   = out_last_q;
  assign out_status_o = out_status_q;

endmodule

`default_nettype wire

/* hdl/crlf_line_ring_buffer_unit.sv */
// push beats are accepted back to back while idle; a full ring drops the byte
// pop: the crlf scan reads the ring port per byte (read, compare) up to the terminator,
// then each line byte takes a ram read and an output load; a status result takes one load
// the ram has a single read port and loads wait for a free output; one pop at a time
// reset (async, active low) clears pointers, fill and line counts and the controller;
// the ring ram is not cleared and needs no clearing pass
`default_nettype none

`include "crlf_line_ring_buffer_unit_defines.svh"

module crlf_line_ring_buffer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // [7:0] data_byte
  input  wire logic       s_axis_tuser,  // [0] mode
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata,  // [7:0] line_byte
  output logic            m_axis_tlast,
  output logic [1:0]      m_axis_tuser   // [1:0] status
);

  clrb_pkg::cmd_t cmd;
  clrb_pkg::sts_t sts;

  // controller
  clrb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_mode_i  (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // datapath with ring ram
  clrb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_byte_i    (s_axis_tdata),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast),
    .out_status_o (m_axis_tuser)
  );

  // checks
  `CLRB_ASSERT_NOW(a_load_when_free,
    cmd.emit_load || cmd.load_noline || cmd.load_empty, sts.out_free,
    "result loaded over a beat not yet taken")
  `CLRB_ASSERT_NOW(a_single_load,
    1'b1, $onehot0({cmd.emit_load, cmd.load_noline, cmd.load_empty, cmd.push}),
    "conflicting datapath commands")
  `CLRB_ASSERT_NEXT(a_pop_busy,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == clrb_pkg::MODE_POP), !s_axis_tready,
    "input taken while a pop is in progress")

endmodule

`default_nettype wire
